// ===== rtl/accel_window_vibration_detector_assert.svh =====
// assertion macros, clocked on clk with asynchronous active-low reset rst_n
`ifndef ACCEL_WINDOW_VIBRATION_DETECTOR_ASSERT_SVH
`define ACCEL_WINDOW_VIBRATION_DETECTOR_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define AWVD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("awvd assertion failed");

// consequent must hold in the cycle after the antecedent
`define AWVD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("awvd assertion failed");

`endif

// ===== rtl/awvd_pkg.sv =====
`timescale 1ns / 1ps

package awvd_pkg;

    localparam int AWVD_WINDOW_LEN = 10;

    localparam int SAMPLE_W = 12;
    localparam int MEAN_W   = 14;
    localparam int ENERGY_W = 28;
    localparam int RUN_W    = 5;
    localparam int LIMIT_W  = 4;
    localparam int CFG_W    = 28;
    localparam int CFG_IDX_W = 3;
    // squared deviation of one sample fits 27 bits (|d| <= 8192)
    localparam int PROD_W   = 27;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QUIET_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST_THRESHOLD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BUSY_RUN_LIMIT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_QUIET_RUN_LIMIT = 3'd6;

    localparam logic [ENERGY_W-1:0] QUIET_THRESHOLD_RST = 28'd1000;
    localparam logic [ENERGY_W-1:0] BURST_THRESHOLD_RST = 28'd5000;
    localparam logic [LIMIT_W-1:0]  BUSY_RUN_LIMIT_RST  = 4'd4;
    localparam logic [LIMIT_W-1:0]  QUIET_RUN_LIMIT_RST = 4'd9;

    localparam logic signed [MEAN_W-1:0] OFFSET_LIMIT = 14'sd4096;
    localparam logic [RUN_W-1:0] RUN_MAX = 5'd31;

    typedef struct packed {
        logic wr;         // store sample, update running sum
        logic first;      // first sample of a window
        logic div_start;  // load divider
        logic div_sel_sq; // divide squared sum instead of sample sum
        logic mean_load;  // latch corrected mean
        logic acc_clear;  // clear squared-deviation accumulator
        logic rd;         // read one window entry for the deviation pass
    } awvd_lane_ctrl_t;

    typedef struct packed {
        logic [ENERGY_W-1:0] quiet_threshold;
        logic [ENERGY_W-1:0] burst_threshold;
        logic [LIMIT_W-1:0]  busy_run_limit;
        logic [LIMIT_W-1:0]  quiet_run_limit;
    } awvd_det_cfg_t;

    function automatic logic signed [MEAN_W-1:0] clamp_offset(
        input logic signed [MEAN_W-1:0] raw
    );
        logic signed [MEAN_W-1:0] o;
        o = raw;
        if (raw > OFFSET_LIMIT)
        begin
            o = OFFSET_LIMIT;
        end
        else if (raw < -OFFSET_LIMIT)
        begin
            o = -OFFSET_LIMIT;
        end
        return o;
    endfunction

endpackage

// ===== rtl/awvd_divider.sv =====
`timescale 1ns / 1ps

// division by a fixed divisor through a reciprocal multiply, quotient registered and valid in the cycle after start
module awvd_divider
    import awvd_pkg::*;
#(
    parameter int W       = 31,
    parameter int DIVISOR = AWVD_WINDOW_LEN
)
(
    input  logic         clk,
    input  logic         start,
    input  logic [W-1:0] dividend,
    output logic [W-1:0] quotient
);

    // with the shift at W + clog2(DIVISOR) the rounded-up reciprocal is exact below 2**W
    localparam int SH = W + $clog2(DIVISOR);
    localparam int RW = W + 1;
    localparam int PW = W + RW;
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [RW-1:0] RECIP_C = RW'(RECIP);

    logic [PW-1:0] prod_reg;
    logic [PW-1:0] prod_next;

    assign prod_next = PW'(dividend) * PW'(RECIP_C);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= prod_next;
        end
    end

    assign quotient = W'(prod_reg >> SH);

endmodule

// ===== rtl/awvd_lane.sv =====
`timescale 1ns / 1ps

// one axis: window memory, running sum, mean, squared-deviation pass
module awvd_lane
    import awvd_pkg::*;
#(
    parameter int WINDOW_LEN = AWVD_WINDOW_LEN
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  awvd_lane_ctrl_t            ctrl,
    input  logic [$clog2(WINDOW_LEN)-1:0] wr_addr,
    input  logic [$clog2(WINDOW_LEN)-1:0] rd_addr,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic signed [MEAN_W-1:0]   offset,
    output logic signed [MEAN_W-1:0]   mean,
    output logic [ENERGY_W-1:0]        share
);

    localparam int LW    = $clog2(WINDOW_LEN);
    localparam int SUM_W = SAMPLE_W + LW;
    localparam int SQ_W  = PROD_W + LW;
    localparam int DIV_W = SQ_W;

    logic signed [SAMPLE_W-1:0] mem [WINDOW_LEN];
    logic signed [SAMPLE_W-1:0] rd_data_reg;

    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [SUM_W-1:0] sample_ext;
    logic [SUM_W-1:0]        sum_abs;
    logic                    neg_reg;

    logic [DIV_W-1:0] div_in;
    logic [DIV_W-1:0] quotient;

    logic signed [SAMPLE_W:0] mean_mag;
    logic signed [MEAN_W-1:0] corr_next;
    logic signed [MEAN_W-1:0] corr_reg;

    logic signed [MEAN_W:0]     diff;
    logic signed [2*MEAN_W+1:0] diff_sq;
    logic [PROD_W-1:0]          prod_reg;
    logic                       v1_reg;
    logic                       v2_reg;
    logic [SQ_W-1:0]            sq_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr)
        begin
            mem[wr_addr] <= sample;
        end
        if (ctrl.rd)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign sample_ext = {{(SUM_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
    assign sum_next   = ctrl.first ? sample_ext : SUM_W'(sum_reg + sample_ext);
    assign sum_abs    = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : sum_reg;
    assign div_in     = ctrl.div_sel_sq ? sq_reg : {{(DIV_W-SUM_W){1'b0}}, sum_abs};

    always_ff @(posedge clk)
    begin
        if (ctrl.wr)
        begin
            sum_reg <= sum_next;
        end
        if (ctrl.div_start && !ctrl.div_sel_sq)
        begin
            neg_reg <= sum_reg[SUM_W-1];
        end
    end

    awvd_divider #(
        .W       (DIV_W),
        .DIVISOR (WINDOW_LEN)
    ) u_div (
        .clk      (clk),
        .start    (ctrl.div_start),
        .dividend (div_in),
        .quotient (quotient)
    );

    // |mean| is at most 2048, so 12 quotient bits carry it
    always_comb
    begin
        mean_mag  = neg_reg ? -$signed({1'b0, quotient[SAMPLE_W-1:0]})
                            :  $signed({1'b0, quotient[SAMPLE_W-1:0]});
        corr_next = MEAN_W'({mean_mag[SAMPLE_W], mean_mag}) + clamp_offset(offset);
    end

    assign diff    = {{3{rd_data_reg[SAMPLE_W-1]}}, rd_data_reg}
                   - {corr_reg[MEAN_W-1], corr_reg};
    assign diff_sq = diff * diff;

    always_ff @(posedge clk)
    begin
        if (ctrl.mean_load)
        begin
            corr_reg <= corr_next;
        end
        if (v1_reg)
        begin
            prod_reg <= diff_sq[PROD_W-1:0];
        end
        if (ctrl.acc_clear)
        begin
            sq_reg <= '0;
        end
        else if (v2_reg)
        begin
            sq_reg <= SQ_W'(sq_reg + {{(SQ_W-PROD_W){1'b0}}, prod_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctrl.rd;
            v2_reg <= v1_reg;
        end
    end

    assign mean  = corr_reg;
    assign share = quotient[ENERGY_W-1:0];

endmodule

// ===== rtl/awvd_merge.sv =====
`timescale 1ns / 1ps

// combines lane results: energy, change detection, run counters, output register
module awvd_merge
    import awvd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req,
    input  logic                     out_stall,
    input  awvd_det_cfg_t            cfg,
    input  logic [ENERGY_W-1:0]      share_x,
    input  logic [ENERGY_W-1:0]      share_y,
    input  logic [ENERGY_W-1:0]      share_z,
    input  logic signed [MEAN_W-1:0] lane_mean_x,
    input  logic signed [MEAN_W-1:0] lane_mean_y,
    input  logic signed [MEAN_W-1:0] lane_mean_z,
    output logic                     done,
    output logic                     out_valid,
    output logic signed [MEAN_W-1:0] mean_x,
    output logic signed [MEAN_W-1:0] mean_y,
    output logic signed [MEAN_W-1:0] mean_z,
    output logic [ENERGY_W-1:0]      energy,
    output logic                     vibrating
);

    logic [ENERGY_W-1:0] e;
    logic [ENERGY_W-1:0] delta;
    logic [ENERGY_W-1:0] prev_energy_reg;
    logic [RUN_W-1:0]    busy_run_reg;
    logic [RUN_W-1:0]    busy_run_next;
    logic [RUN_W-1:0]    quiet_run_reg;
    logic [RUN_W-1:0]    quiet_run_next;
    logic                flag_reg;
    logic                flag_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    logic signed [MEAN_W-1:0] mean_x_reg;
    logic signed [MEAN_W-1:0] mean_y_reg;
    logic signed [MEAN_W-1:0] mean_z_reg;
    logic [ENERGY_W-1:0]      energy_reg;

    assign done = req && (!out_valid_reg || !out_stall);
    assign e    = ENERGY_W'(share_x + share_y + share_z);
    assign delta = (e < prev_energy_reg) ? ENERGY_W'(prev_energy_reg - e)
                                         : ENERGY_W'(e - prev_energy_reg);

    always_comb
    begin
        busy_run_next  = busy_run_reg;
        quiet_run_next = quiet_run_reg;
        flag_next      = flag_reg;
        if (delta < cfg.quiet_threshold)
        begin
            busy_run_next = '0;
            if (quiet_run_reg < RUN_MAX)
            begin
                quiet_run_next = RUN_W'(quiet_run_reg + 1'b1);
            end
        end
        else
        begin
            if (busy_run_reg < RUN_MAX)
            begin
                busy_run_next = RUN_W'(busy_run_reg + 1'b1);
            end
            quiet_run_next = '0;
        end
        if (delta > cfg.burst_threshold
            || busy_run_next > {1'b0, cfg.busy_run_limit})
        begin
            flag_next     = 1'b1;
            busy_run_next = '0;
        end
        if (quiet_run_next > {1'b0, cfg.quiet_run_limit})
        begin
            flag_next      = 1'b0;
            quiet_run_next = '0;
        end
    end

    assign out_valid_next = done || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_energy_reg <= '0;
            busy_run_reg    <= '0;
            quiet_run_reg   <= '0;
            flag_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (done)
            begin
                prev_energy_reg <= e;
                busy_run_reg    <= busy_run_next;
                quiet_run_reg   <= quiet_run_next;
                flag_reg        <= flag_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            mean_x_reg <= lane_mean_x;
            mean_y_reg <= lane_mean_y;
            mean_z_reg <= lane_mean_z;
            energy_reg <= e;
        end
    end

    assign out_valid = out_valid_reg;
    assign mean_x    = mean_x_reg;
    assign mean_y    = mean_y_reg;
    assign mean_z    = mean_z_reg;
    assign energy    = energy_reg;
    assign vibrating = flag_reg;

endmodule

// ===== rtl/accel_window_vibration_detector.sv =====
// sequence after the last sample of a window: reciprocal-multiply division of the sample sum,
//   the deviation pass over the stored window, division of the squared sum, then one merge
// input: WINDOW_LEN samples at one per cycle while idle, then the steps above; no new window is
//   taken before the merge completes, as in_stall is high in every state but idle, and longer
//   while a finished result waits on out_stall
// reset: control, run counters and energy history clear, registers take defaults; window not cleared
`timescale 1ns / 1ps

`include "accel_window_vibration_detector_assert.svh"

module accel_window_vibration_detector
    import awvd_pkg::*;
#(
    parameter int WINDOW_LEN = AWVD_WINDOW_LEN
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] sample_x,
    input  logic signed [SAMPLE_W-1:0] sample_y,
    input  logic signed [SAMPLE_W-1:0] sample_z,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [MEAN_W-1:0]   mean_x,
    output logic signed [MEAN_W-1:0]   mean_y,
    output logic signed [MEAN_W-1:0]   mean_z,
    output logic [ENERGY_W-1:0]        energy,
    output logic                       vibrating,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]           cfg_data
);

    localparam int AW    = $clog2(WINDOW_LEN);
    localparam int CNT_W = $clog2(WINDOW_LEN + 2);

    localparam logic [AW-1:0]    FILL_LAST = AW'(WINDOW_LEN - 1);
    localparam logic [CNT_W-1:0] PASS_RD   = CNT_W'(WINDOW_LEN);
    localparam logic [CNT_W-1:0] PASS_END  = CNT_W'(WINDOW_LEN + 1);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_DIV_MEAN = 5'b00010,
        S_PASS     = 5'b00100,
        S_DIV_SQ   = 5'b01000,
        S_MERGE    = 5'b10000
    } awvd_state_t;

    awvd_state_t      state_reg;
    awvd_state_t      state_next;
    logic [AW-1:0]    fill_reg;
    logic [AW-1:0]    fill_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    logic signed [MEAN_W-1:0] offset_x_reg;
    logic signed [MEAN_W-1:0] offset_y_reg;
    logic signed [MEAN_W-1:0] offset_z_reg;
    awvd_det_cfg_t            det_cfg_reg;

    awvd_lane_ctrl_t lane_ctrl;
    logic [AW-1:0]   rd_addr;
    logic            in_accept;
    logic            merge_done;

    logic [ENERGY_W-1:0]      share_x;
    logic [ENERGY_W-1:0]      share_y;
    logic [ENERGY_W-1:0]      share_z;
    logic signed [MEAN_W-1:0] lane_mean_x;
    logic signed [MEAN_W-1:0] lane_mean_y;
    logic signed [MEAN_W-1:0] lane_mean_z;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign rd_addr   = cnt_reg[AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        cnt_next   = cnt_reg;
        lane_ctrl  = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                lane_ctrl.wr    = in_accept;
                lane_ctrl.first = (fill_reg == '0);
                if (in_accept)
                begin
                    if (fill_reg == FILL_LAST)
                    begin
                        fill_next  = '0;
                        cnt_next   = '0;
                        state_next = S_DIV_MEAN;
                    end
                    else
                    begin
                        fill_next = AW'(fill_reg + 1'b1);
                    end
                end
            end
            S_DIV_MEAN:
            begin
                lane_ctrl.div_start = 1'b1;
                cnt_next            = '0;
                state_next          = S_PASS;
            end
            S_PASS:
            begin
                // mean latched first; a read is registered, squared into prod_reg, then summed
                lane_ctrl.mean_load = (cnt_reg == '0);
                lane_ctrl.acc_clear = (cnt_reg == '0);
                lane_ctrl.rd        = (cnt_reg < PASS_RD);
                if (cnt_reg == PASS_END)
                begin
                    cnt_next   = '0;
                    state_next = S_DIV_SQ;
                end
                else
                begin
                    cnt_next = CNT_W'(cnt_reg + 1'b1);
                end
            end
            S_DIV_SQ:
            begin
                lane_ctrl.div_sel_sq = 1'b1;
                lane_ctrl.div_start  = 1'b1;
                cnt_next             = '0;
                state_next           = S_MERGE;
            end
            S_MERGE:
            begin
                if (merge_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg                <= '0;
            offset_y_reg                <= '0;
            offset_z_reg                <= '0;
            det_cfg_reg.quiet_threshold <= QUIET_THRESHOLD_RST;
            det_cfg_reg.burst_threshold <= BURST_THRESHOLD_RST;
            det_cfg_reg.busy_run_limit  <= BUSY_RUN_LIMIT_RST;
            det_cfg_reg.quiet_run_limit <= QUIET_RUN_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OFFSET_X:        offset_x_reg <= cfg_data[MEAN_W-1:0];
                CFG_OFFSET_Y:        offset_y_reg <= cfg_data[MEAN_W-1:0];
                CFG_OFFSET_Z:        offset_z_reg <= cfg_data[MEAN_W-1:0];
                CFG_QUIET_THRESHOLD: det_cfg_reg.quiet_threshold <= cfg_data[ENERGY_W-1:0];
                CFG_BURST_THRESHOLD: det_cfg_reg.burst_threshold <= cfg_data[ENERGY_W-1:0];
                CFG_BUSY_RUN_LIMIT:  det_cfg_reg.busy_run_limit <= cfg_data[LIMIT_W-1:0];
                CFG_QUIET_RUN_LIMIT: det_cfg_reg.quiet_run_limit <= cfg_data[LIMIT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    awvd_lane #(.WINDOW_LEN(WINDOW_LEN)) u_lane_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (lane_ctrl),
        .wr_addr (fill_reg),
        .rd_addr (rd_addr),
        .sample  (sample_x),
        .offset  (offset_x_reg),
        .mean    (lane_mean_x),
        .share   (share_x)
    );

    awvd_lane #(.WINDOW_LEN(WINDOW_LEN)) u_lane_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (lane_ctrl),
        .wr_addr (fill_reg),
        .rd_addr (rd_addr),
        .sample  (sample_y),
        .offset  (offset_y_reg),
        .mean    (lane_mean_y),
        .share   (share_y)
    );

    awvd_lane #(.WINDOW_LEN(WINDOW_LEN)) u_lane_z (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (lane_ctrl),
        .wr_addr (fill_reg),
        .rd_addr (rd_addr),
        .sample  (sample_z),
        .offset  (offset_z_reg),
        .mean    (lane_mean_z),
        .share   (share_z)
    );

    awvd_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (state_reg == S_MERGE),
        .out_stall   (out_stall),
        .cfg         (det_cfg_reg),
        .share_x     (share_x),
        .share_y     (share_y),
        .share_z     (share_z),
        .lane_mean_x (lane_mean_x),
        .lane_mean_y (lane_mean_y),
        .lane_mean_z (lane_mean_z),
        .done        (merge_done),
        .out_valid   (out_valid),
        .mean_x      (mean_x),
        .mean_y      (mean_y),
        .mean_z      (mean_z),
        .energy      (energy),
        .vibrating   (vibrating)
    );

    // window full starts the mean division
    `AWVD_ASSERT_NEXT(a_full_starts_div, in_accept && fill_reg == FILL_LAST, state_reg == S_DIV_MEAN && cnt_reg == '0)
    // fill pointer sits at zero while a window is being worked on
    `AWVD_ASSERT_SAME(a_fill_zero_busy, state_reg != S_IDLE, fill_reg == '0)
    // a new result only comes out of the merge step
    `AWVD_ASSERT_SAME(a_result_from_merge, $rose(out_valid), $past(state_reg) == S_MERGE)
    // pass ends with the squared-sum division from its first step
    `AWVD_ASSERT_NEXT(a_pass_to_div, state_reg == S_PASS && cnt_reg == PASS_END, state_reg == S_DIV_SQ && cnt_reg == '0)

endmodule
